[rtl/srcr_pkg.sv]
// Package for the score-ranked cache replacement block.
// Holds the word types, the table entry type, the control states and defaults.
// No dependencies.
package srcr_pkg;

  localparam int unsigned ENTRIES_DEF   = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] url_key;
    logic [63:0] path_key;
    logic [31:0] body_handle;
    logic [31:0] body_size;
    logic [31:0] fetch_latency;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic [31:0] found_size;
    logic [31:0] found_latency;
    logic [31:0] found_frequency;
    logic        accepted;
    logic        evicted;
    logic [31:0] evicted_handle;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [6:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic [63:0] url_key;
    logic [63:0] path_key;
    logic [31:0] handle;
    logic [31:0] size;
    logic [31:0] latency;
    logic [31:0] frequency;
    logic [63:0] score;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_REMOVE,
    ST_FIND,
    ST_SHIFT,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage

[rtl/score_ranked_cache_replacement.sv]
// Top level of the score-ranked cache replacement table.
// Depends on srcr_pkg and srcr_score_div.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_word_i) carries one
// word per lookup or insert; the output channel (out_valid_o, out_stall_i,
// out_word_o) returns exactly one result word per input word, in order.
// A word is taken at a clock edge where valid is high and stall is low.
// Entries are kept in a single table memory in score order, rank 0 highest.
// One word is worked on at a time. A lookup scans the table one rank a cycle;
// a hit then multiplies, divides one bit a cycle, closes the gap, searches
// the new rank and opens a gap, each one rank a cycle through the single
// memory port pair. An insert multiplies, divides, searches and, unless the
// new entry itself is evicted, shifts the same way. A miss on an empty table
// and a zero-size insert go straight to the result; a hit takes longest.
// The result sits in an output register; while the receiver stalls the next
// word is already worked on up to its result, then waits.
// Reset empties the table, clears the counters and sets capacity to 64; the
// table needs no clearing pass. cfg_we_i writes the capacity register.
module score_ranked_cache_replacement #(
  parameter int unsigned ENTRIES         = srcr_pkg::ENTRIES_DEF,
  parameter int unsigned SCORE_FRAC_BITS = srcr_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  srcr_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srcr_pkg::out_word_t  out_word_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  srcr_pkg::slot_t mem [ENTRIES];
  srcr_pkg::slot_t rdata_q, wr_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;

  srcr_pkg::state_e   state_q, state_d;
  srcr_pkg::in_word_t in_q, in_d;
  srcr_pkg::slot_t    e_q, e_d;
  srcr_pkg::out_word_t out_q, out_d;
  logic [CW-1:0] n_q, n_d, addr_q, addr_d, cidx_q, cidx_d, pos_q, pos_d, m_q, m_d;
  logic          dv_q, dv_d, hitf_q, hitf_d, accf_q, accf_d, full_q, full_d;
  logic          evf_q, evf_d, out_valid_q, out_valid_d;
  logic [31:0]   evh_q, evh_d, hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d;
  logic [6:0]    cap_q;
  logic [63:0]   prod_q, prod_d;
  logic          div_start, div_done;
  logic [63:0]   div_score;
  logic [31:0]   eff_cap;
  logic          find_done, find_cond;
  logic [CW-1:0] find_pos;
  logic          div_pend_q;

  srcr_score_div #(
    .SCORE_FRAC_BITS(SCORE_FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .product_i(prod_q),
    .size_i   (e_q.size),
    .done_o   (div_done),
    .score_o  (div_score)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  assign eff_cap    = (32'(cap_q) > ENTRIES) ? ENTRIES : 32'(cap_q);
  assign in_stall_o = (state_q != srcr_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    e_d         = e_q;
    out_d       = out_q;
    n_d         = n_q;
    addr_d      = addr_q;
    cidx_d      = cidx_q;
    pos_d       = pos_q;
    m_d         = m_q;
    dv_d        = dv_q;
    hitf_d      = hitf_q;
    accf_d      = accf_q;
    full_d      = full_q;
    evf_d       = evf_q;
    evh_d       = evh_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    rd_addr     = addr_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pos_q[AW-1:0];
    wr_data     = e_q;
    find_done   = 1'b0;
    find_pos    = m_q;
    find_cond   = 1'b0;

    case (state_q)
      srcr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_d   = in_word_i;
          hitf_d = 1'b0;
          accf_d = 1'b0;
          evf_d  = 1'b0;
          evh_d  = '0;
          addr_d = '0;
          dv_d   = 1'b0;
          if (in_word_i.kind == srcr_pkg::KIND_LOOKUP) begin
            state_d = (n_q == '0) ? srcr_pkg::ST_OUT : srcr_pkg::ST_SCAN;
          end else if (in_word_i.body_size == '0) begin
            state_d = srcr_pkg::ST_OUT;
          end else begin
            accf_d      = 1'b1;
            e_d.url_key  = in_word_i.url_key;
            e_d.path_key = in_word_i.path_key;
            e_d.handle   = in_word_i.body_handle;
            e_d.size     = in_word_i.body_size;
            e_d.latency  = in_word_i.fetch_latency;
            e_d.frequency = 32'd1;
            e_d.score    = '0;
            full_d      = (32'(n_q) >= eff_cap);
            m_d         = n_q;
            state_d     = srcr_pkg::ST_MUL;
          end
        end
      end

      srcr_pkg::ST_SCAN: begin
        addr_d = addr_q + 1'b1;
        cidx_d = addr_q;
        dv_d   = 1'b1;
        if (dv_q) begin
          if (rdata_q.url_key == in_q.url_key && rdata_q.path_key == in_q.path_key) begin
            e_d = rdata_q;
            if (rdata_q.frequency != '1) begin
              e_d.frequency = rdata_q.frequency + 1'b1;
            end
            hitf_d  = 1'b1;
            pos_d   = cidx_q;
            m_d     = n_q - 1'b1;
            state_d = srcr_pkg::ST_MUL;
          end else if (cidx_q == n_q - 1'b1) begin
            state_d = srcr_pkg::ST_OUT;
          end
        end
      end

      srcr_pkg::ST_MUL: begin
        prod_d = 64'(e_q.frequency) * 64'(e_q.latency);
        // A stored entry of size zero is kept at the highest score.
        if (e_q.size == '0) begin
          e_d.score = '1;
          addr_d    = pos_q + 1'b1;
          dv_d      = 1'b0;
          state_d   = srcr_pkg::ST_REMOVE;
        end else begin
          state_d = srcr_pkg::ST_DIV;
        end
      end

      srcr_pkg::ST_DIV: begin
        div_start = div_pend_q;
        if (div_done) begin
          e_d.score = div_score;
          dv_d      = 1'b0;
          if (hitf_q) begin
            addr_d  = pos_q + 1'b1;
            state_d = srcr_pkg::ST_REMOVE;
          end else begin
            addr_d  = '0;
            state_d = srcr_pkg::ST_FIND;
          end
        end
      end

      // Close the gap left by the hit entry: rank k moves to k - 1.
      srcr_pkg::ST_REMOVE: begin
        addr_d = addr_q + 1'b1;
        cidx_d = addr_q;
        dv_d   = 1'b1;
        if (!dv_q && addr_q >= n_q) begin
          addr_d  = '0;
          dv_d    = 1'b0;
          state_d = srcr_pkg::ST_FIND;
        end else if (dv_q) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cidx_q - 1'b1);
          wr_data = rdata_q;
          if (cidx_q == n_q - 1'b1) begin
            addr_d  = '0;
            dv_d    = 1'b0;
            state_d = srcr_pkg::ST_FIND;
          end
        end
      end

      // First rank whose score is below the new one; rank 0 also yields on a tie.
      srcr_pkg::ST_FIND: begin
        addr_d = addr_q + 1'b1;
        cidx_d = addr_q;
        dv_d   = 1'b1;
        if (!dv_q && m_q == '0) begin
          find_done = 1'b1;
          find_pos  = '0;
        end else if (dv_q) begin
          find_cond = (cidx_q == '0) ? (rdata_q.score <= e_q.score)
                                     : (rdata_q.score < e_q.score);
          if (find_cond) begin
            find_done = 1'b1;
            find_pos  = cidx_q;
          end else if (cidx_q == m_q - 1'b1) begin
            find_done = 1'b1;
            find_pos  = m_q;
          end
        end
        if (find_done) begin
          pos_d  = find_pos;
          addr_d = m_q - 1'b1;
          dv_d   = 1'b0;
          evf_d  = accf_q && full_q;
          if (accf_q && full_q && find_pos >= n_q) begin
            evh_d   = e_q.handle;
            state_d = srcr_pkg::ST_OUT;
          end else begin
            state_d = srcr_pkg::ST_SHIFT;
          end
        end
      end

      // Open a gap at the new rank: rank k moves to k + 1, from the bottom up.
      // On a full insert the bottom entry is not copied but evicted.
      srcr_pkg::ST_SHIFT: begin
        addr_d = addr_q - 1'b1;
        cidx_d = addr_q;
        dv_d   = 1'b1;
        if (!dv_q && pos_q == m_q) begin
          state_d = srcr_pkg::ST_WRITE;
        end else if (dv_q) begin
          if (evf_q && cidx_q == n_q - 1'b1) begin
            evh_d = rdata_q.handle;
          end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(cidx_q + 1'b1);
            wr_data = rdata_q;
          end
          if (cidx_q == pos_q) begin
            state_d = srcr_pkg::ST_WRITE;
          end
        end
      end

      srcr_pkg::ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = e_q;
        state_d = srcr_pkg::ST_OUT;
      end

      srcr_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (hitf_q && hit_cnt_q != '1) begin
            hit_cnt_d = hit_cnt_q + 1'b1;
          end
          if (in_q.kind == srcr_pkg::KIND_LOOKUP && !hitf_q && miss_cnt_q != '1) begin
            miss_cnt_d = miss_cnt_q + 1'b1;
          end
          if (accf_q && !full_q) begin
            n_d = n_q + 1'b1;
          end
          out_d.hit             = hitf_q;
          out_d.found_handle    = hitf_q ? e_q.handle : '0;
          out_d.found_size      = hitf_q ? e_q.size : '0;
          out_d.found_latency   = hitf_q ? e_q.latency : '0;
          out_d.found_frequency = hitf_q ? e_q.frequency : '0;
          out_d.accepted        = accf_q;
          out_d.evicted         = evf_q;
          out_d.evicted_handle  = evh_q;
          out_d.hit_total       = hit_cnt_d;
          out_d.miss_total      = miss_cnt_d;
          out_d.entry_count     = 7'(n_d);
          state_d               = srcr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = srcr_pkg::ST_IDLE;
      end
    endcase
  end

  // The divider is kicked once, the cycle after the product is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
    end else begin
      div_pend_q <= (state_q == srcr_pkg::ST_MUL) && (e_q.size != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srcr_pkg::ST_IDLE;
      n_q         <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      cap_q       <= 7'd64;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      hitf_q      <= 1'b0;
      accf_q      <= 1'b0;
      full_q      <= 1'b0;
      evf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
      dv_q        <= dv_d;
      hitf_q      <= hitf_d;
      accf_q      <= accf_d;
      full_q      <= full_d;
      evf_q       <= evf_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    e_q    <= e_d;
    out_q  <= out_d;
    addr_q <= addr_d;
    cidx_q <= cidx_d;
    pos_q  <= pos_d;
    m_q    <= m_d;
    evh_q  <= evh_d;
    prod_q <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[rtl/srcr_score_div.sv]
// Restoring divider for the score: floor(product * 2^FRAC / size), saturated.
// One quotient bit per cycle. Depends on srcr_pkg for its default.
module srcr_score_div #(
  parameter int unsigned SCORE_FRAC_BITS = srcr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] product_i,
  input  logic [31:0] size_i,
  output logic        done_o,
  output logic [63:0] score_o
);

  localparam int unsigned DW = 64 + SCORE_FRAC_BITS;
  localparam int unsigned KW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [32:0]   rem_q, rem_d, trial;
  logic [31:0]   size_q, size_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    size_d = size_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], dvd_q[DW-1]};
    if (start_i) begin
      dvd_d  = DW'(product_i) << SCORE_FRAC_BITS;
      quo_d  = '0;
      rem_d  = '0;
      size_d = size_i;
      cnt_d  = KW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, size_q}) begin
        rem_d = trial - {1'b0, size_q};
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == KW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    size_q <= size_d;
  end

  // A quotient that needs more than 64 bits saturates to all ones.
  assign done_o  = done_q;
  assign score_o = ((quo_q >> 64) != '0) ? '1 : quo_q[63:0];

endmodule

[verif/score_ranked_cache_replacement_test.sv]
// Self-checking testbench for the score-ranked cache replacement table.
// Drives lookups and inserts, predicts each result word and checks it.
// Depends on srcr_pkg and the RTL of score_ranked_cache_replacement.
`timescale 1ns / 100ps

module score_ranked_cache_replacement_test;

  localparam int unsigned DEPTH       = srcr_pkg::ENTRIES_DEF;
  localparam int unsigned FRAC        = srcr_pkg::FRAC_BITS_DEF;
  localparam int unsigned SETTLE      = 3 * DEPTH + 64 + FRAC + 40;
  localparam longint      CYCLE_LIMIT = 6000000;
  localparam int          HOLD_CYCLES = 1500;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [6:0]           cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  srcr_pkg::in_word_t   in_word_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  srcr_pkg::out_word_t  out_word_o;

  score_ranked_cache_replacement uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted table contents, rank 0 holds the highest score.
  srcr_pkg::slot_t table_q [DEPTH];
  int unsigned held_n;
  logic [31:0] hits_n, misses_n;
  int unsigned cap_n;

  srcr_pkg::out_word_t pending_results [$];
  int          errors = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_used = 1'b0;
  longint      cycles = 0;

  // Recently inserted keys, so that lookups find something.
  logic [63:0] known_url [$], known_path [$];

  function automatic logic [63:0] gdsf_score(logic [31:0] freq, logic [31:0] lat,
                                             logic [31:0] size);
    logic [63:0] prod, quo, rem;
    prod = 64'(freq) * 64'(lat);
    quo  = prod / 64'(size);
    rem  = prod % 64'(size);
    if ((quo >> (63 - FRAC)) >> 1 != 0) return '1;
    return (quo << FRAC) + ((rem << FRAC) / 64'(size));
  endfunction

  function automatic int unsigned rank_for(logic [63:0] s, int unsigned n);
    if (n == 0 || s >= table_q[0].score) return 0;
    for (int unsigned i = 0; i < n; i++)
      if (table_q[i].score < s) return i;
    return n;
  endfunction

  function automatic void place_at(int unsigned pos, int unsigned m, srcr_pkg::slot_t e);
    if (m >= DEPTH || pos > m) return;
    for (int unsigned i = m; i > pos; i--) table_q[i] = table_q[i - 1];
    table_q[pos] = e;
  endfunction

  function automatic srcr_pkg::out_word_t cache_step(srcr_pkg::in_word_t w);
    srcr_pkg::out_word_t r;
    srcr_pkg::slot_t     e;
    int unsigned n, lim, i, pos;
    r = '0;
    n = held_n;
    lim = (cap_n > DEPTH) ? DEPTH : cap_n;
    e.url_key = w.url_key;
    e.path_key = w.path_key;
    e.handle = w.body_handle;
    e.size = w.body_size;
    e.latency = w.fetch_latency;
    if (w.kind == srcr_pkg::KIND_LOOKUP) begin
      for (i = 0; i < n; i++)
        if (table_q[i].url_key == w.url_key && table_q[i].path_key == w.path_key) break;
      if (i < n) begin
        e = table_q[i];
        if (e.frequency != '1) e.frequency++;
        e.score = (e.size != 0) ? gdsf_score(e.frequency, e.latency, e.size) : '1;
        for (int unsigned j = i; j + 1 < n; j++) table_q[j] = table_q[j + 1];
        pos = rank_for(e.score, n - 1);
        place_at(pos, n - 1, e);
        if (hits_n != '1) hits_n++;
        r.hit = 1'b1;
        r.found_handle = e.handle;
        r.found_size = e.size;
        r.found_latency = e.latency;
        r.found_frequency = e.frequency;
      end else if (misses_n != '1) begin
        misses_n++;
      end
    end else if (w.body_size != 0) begin
      r.accepted = 1'b1;
      e.frequency = 32'd1;
      e.score = gdsf_score(32'd1, e.latency, e.size);
      pos = rank_for(e.score, n);
      if (n >= lim) begin
        r.evicted = 1'b1;
        if (pos >= n) begin
          r.evicted_handle = e.handle;
        end else begin
          r.evicted_handle = table_q[n - 1].handle;
          place_at(pos, n - 1, e);
        end
      end else begin
        place_at(pos, n, e);
        n++;
      end
      held_n = n;
    end
    r.hit_total = hits_n;
    r.miss_total = misses_n;
    r.entry_count = 7'(held_n);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Outputs are sampled mid-cycle; a word seen here is taken at the next rising edge.
  always @(negedge clk_i) begin
    srcr_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, actual %0h", $time, out_word_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 64'(want.hit), 64'(out_word_o.hit));
        check_field("found_handle", 64'(want.found_handle), 64'(out_word_o.found_handle));
        check_field("found_size", 64'(want.found_size), 64'(out_word_o.found_size));
        check_field("found_latency", 64'(want.found_latency),
                    64'(out_word_o.found_latency));
        check_field("found_frequency", 64'(want.found_frequency),
                    64'(out_word_o.found_frequency));
        check_field("accepted", 64'(want.accepted), 64'(out_word_o.accepted));
        check_field("evicted", 64'(want.evicted), 64'(out_word_o.evicted));
        check_field("evicted_handle", 64'(want.evicted_handle),
                    64'(out_word_o.evicted_handle));
        check_field("hit_total", 64'(want.hit_total), 64'(out_word_o.hit_total));
        check_field("miss_total", 64'(want.miss_total), 64'(out_word_o.miss_total));
        check_field("entry_count", 64'(want.entry_count), 64'(out_word_o.entry_count));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here when requested.
  always @(posedge clk_i) begin
    if (hold_req && !hold_used) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(srcr_pkg::in_word_t w, bit typed, srcr_pkg::out_word_t typed_res);
    logic taken;
    srcr_pkg::out_word_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do begin
      @(negedge clk_i);
      taken = in_stall_o === 1'b0;
      @(posedge clk_i);
    end while (!taken);
    r = cache_step(w);
    pending_results.push_back(typed ? typed_res : r);
    if (w.kind == srcr_pkg::KIND_INSERT && w.body_size != 0) begin
      known_url.push_back(w.url_key);
      known_path.push_back(w.path_key);
      if (known_url.size() > 96) begin
        void'(known_url.pop_front());
        void'(known_path.pop_front());
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [6:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_n = 32'(v);
  endtask

  function automatic srcr_pkg::in_word_t make_word(logic kind, logic [63:0] url,
                                                   logic [63:0] path, logic [31:0] hnd,
                                                   logic [31:0] size, logic [31:0] lat);
    srcr_pkg::in_word_t w;
    w.kind = kind;
    w.url_key = url;
    w.path_key = path;
    w.body_handle = hnd;
    w.body_size = size;
    w.fetch_latency = lat;
    return w;
  endfunction

  function automatic srcr_pkg::in_word_t random_word();
    srcr_pkg::in_word_t w;
    int unsigned k;
    w.url_key = {$urandom(), $urandom()};
    w.path_key = {$urandom(), $urandom()};
    w.body_handle = $urandom();
    case ($urandom_range(0, 3))
      0: w.body_size = $urandom();
      1: w.body_size = $urandom_range(1, 4);
      default: w.body_size = $urandom_range(1, 2000);
    endcase
    if ($urandom_range(0, 19) == 0) w.body_size = '0;
    w.fetch_latency = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20);
    w.kind = ($urandom_range(0, 99) < 45) ? srcr_pkg::KIND_INSERT : srcr_pkg::KIND_LOOKUP;
    if (known_url.size() != 0 && $urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, known_url.size() - 1);
      w.url_key = known_url[k];
      // Same url with another path must still miss.
      w.path_key = ($urandom_range(0, 9) == 0) ? ~known_path[k] : known_path[k];
    end
    return w;
  endfunction

  typedef struct {
    srcr_pkg::in_word_t  w;
    bit                  typed;
    srcr_pkg::out_word_t res;
  } stim_row_t;

  stim_row_t   directed [14];
  logic [6:0]  phase_cap [7] = '{7'd8, 7'd0, 7'd127, 7'd3, 7'd64, 7'd1, 7'd64};
  localparam logic [63:0] ONES = '1;

  initial begin
    for (int unsigned i = 0; i < DEPTH; i++) table_q[i] = '0;
    held_n = 0;
    hits_n = '0;
    misses_n = '0;
    cap_n = 64;

    directed[0]  = '{make_word(srcr_pkg::KIND_LOOKUP, 64'd1, 64'd1, 0, 0, 0), 1'b1,
                     '{miss_total: 32'd1, default: '0}};
    directed[1]  = '{make_word(srcr_pkg::KIND_INSERT, 64'd1, 64'd1, 32'hAAAA, 0, 5), 1'b1,
                     '{miss_total: 32'd1, default: '0}};
    directed[2]  = '{make_word(srcr_pkg::KIND_INSERT, 64'd1, 64'd1, 32'hAAAA, 1, '1), 1'b1,
                     '{accepted: 1'b1, miss_total: 32'd1, entry_count: 7'd1, default: '0}};
    directed[3]  = '{make_word(srcr_pkg::KIND_LOOKUP, 64'd1, 64'd1, 0, 0, 0), 1'b1,
                     '{hit: 1'b1, found_handle: 32'hAAAA, found_size: 32'd1,
                       found_latency: '1, found_frequency: 32'd2, hit_total: 32'd1,
                       miss_total: 32'd1, entry_count: 7'd1, default: '0}};
    directed[4]  = '{make_word(srcr_pkg::KIND_INSERT, ONES, ONES, '1, '1, 0), 1'b0, '0};
    directed[5]  = '{make_word(srcr_pkg::KIND_INSERT, ONES, 64'd0, 0, 1, 0), 1'b0, '0};
    directed[6]  = '{make_word(srcr_pkg::KIND_LOOKUP, ONES, ONES, 0, 0, 0), 1'b0, '0};
    directed[7]  = '{make_word(srcr_pkg::KIND_LOOKUP, ONES, 64'd1, '1, '1, '1), 1'b0, '0};
    directed[8]  = '{make_word(srcr_pkg::KIND_INSERT, 64'd1, 64'd1, 32'd5, 3, 7), 1'b0, '0};
    directed[9]  = '{make_word(srcr_pkg::KIND_INSERT, 64'd1, 64'd1, 32'd6, 3, 7), 1'b0, '0};
    directed[10] = '{make_word(srcr_pkg::KIND_LOOKUP, 64'd1, 64'd1, 0, 0, 0), 1'b0, '0};
    directed[11] = '{make_word(srcr_pkg::KIND_INSERT, 64'd2, 64'd2, 32'd7, '1, '1), 1'b0, '0};
    directed[12] = '{make_word(srcr_pkg::KIND_LOOKUP, 64'd2, 64'd2, 0, 0, 0), 1'b0, '0};
    directed[13] = '{make_word(srcr_pkg::KIND_LOOKUP, 64'd0, 64'd0, 0, 0, 0), 1'b0, '0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].res);

    for (int ph = 0; ph < 7; ph++) begin
      write_capacity(phase_cap[ph]);
      if (ph < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 76;
      end else if (ph < 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Long receiver hold-off while words keep coming, so the input backs up.
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 220; n++) begin
        send_word(random_word(), 1'b0, '0);
        // Pause the sender until everything has come back.
        if (n == 110) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/srcr_pkg.sv
rtl/srcr_score_div.sv
rtl/score_ranked_cache_replacement.sv
verif/score_ranked_cache_replacement_test.sv
